[rtl/gmfv_pkg.sv]
// ----------------------------------------------------------------------------
// gmfv_pkg
// Shared types and constants for the grid map format validator.
// ----------------------------------------------------------------------------
`default_nettype none

package gmfv_pkg;

  localparam logic [31:0] COUNT_CAP  = 32'd429496728;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [7:0]  PRINT_LO   = 8'd32;
  localparam logic [7:0]  PRINT_HI   = 8'd126;
  localparam logic [7:0]  DIGIT_ZERO = 8'd48;
  localparam logic [7:0]  DIGIT_NINE = 8'd57;
  localparam logic [7:0]  NEWLINE    = 8'd10;
  localparam logic [5:0]  HBC_MAX    = 6'd63;
  localparam logic [5:0]  HBC_WINDOW = 6'd3;

  // Item queue between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_MAP    = 2'd1
  } phase_e;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_HDR_CHAR   = 4'd1,
    ERR_DIGIT      = 4'd2,
    ERR_HDR_VALUE  = 4'd3,
    ERR_MAP_CHAR   = 4'd4,
    ERR_RAGGED     = 4'd5,
    ERR_ROW_TOTAL  = 4'd6,
    ERR_EMPTY_ROW  = 4'd7,
    ERR_TRUNCATED  = 4'd8
  } err_e;

  // Classified item, as queued from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       is_nl;
    logic       is_print;
    logic       is_digit;
  } q_entry_t;

endpackage

`default_nettype wire

[rtl/gmfv_if.sv]
// ----------------------------------------------------------------------------
// gmfv_in_if / gmfv_out_if
// Valid/ready channels for file bytes in and verdicts out.
// ----------------------------------------------------------------------------
`default_nettype none

interface gmfv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface gmfv_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [3:0]  error_code;
  logic [31:0] row_count;
  logic [31:0] row_length;
  logic [7:0]  empty_symbol;
  logic [7:0]  obstacle_symbol;
  logic [7:0]  fill_symbol;

  modport source (output valid, output valid_res, output error_code, output row_count,
                  output row_length, output empty_symbol, output obstacle_symbol,
                  output fill_symbol, input ready);
  modport sink   (input valid, input valid_res, input error_code, input row_count,
                  input row_length, input empty_symbol, input obstacle_symbol,
                  input fill_symbol, output ready);
endinterface

`default_nettype wire

[rtl/gmfv_front.sv]
// ----------------------------------------------------------------------------
// gmfv_front
// Accept bytes and classify them (newline, printable, digit) for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gmfv_front (
  gmfv_in_if.sink            in_i,
  input  wire logic          q_ready_i,
  output gmfv_pkg::q_entry_t q_entry_o,
  output logic               q_push_o
);

  assign in_i.ready = q_ready_i;
  assign q_push_o   = in_i.valid && q_ready_i;

  always_comb begin
    q_entry_o.data     = in_i.data_byte;
    q_entry_o.eof      = in_i.end_of_file;
    q_entry_o.is_nl    = (in_i.data_byte == gmfv_pkg::NEWLINE);
    q_entry_o.is_print = (in_i.data_byte >= gmfv_pkg::PRINT_LO) &&
                         (in_i.data_byte <= gmfv_pkg::PRINT_HI);
    q_entry_o.is_digit = (in_i.data_byte >= gmfv_pkg::DIGIT_ZERO) &&
                         (in_i.data_byte <= gmfv_pkg::DIGIT_NINE);
  end

endmodule

`default_nettype wire

[rtl/gmfv_fifo.sv]
// ----------------------------------------------------------------------------
// gmfv_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gmfv_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire gmfv_pkg::q_entry_t push_data_i,
  output logic                    not_full_o,
  input  wire logic               pop_i,
  output gmfv_pkg::q_entry_t      pop_data_o,
  output logic                    not_empty_o
);

  gmfv_pkg::q_entry_t        mem_q [gmfv_pkg::QDEPTH];
  logic [gmfv_pkg::QAW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [gmfv_pkg::QAW:0]    cnt_q, cnt_d;

  assign not_full_o  = (cnt_q != (gmfv_pkg::QAW+1)'(gmfv_pkg::QDEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/gmfv_back.sv]
// ----------------------------------------------------------------------------
// gmfv_back
// Apply queued items to the parse state; register the verdict at end of file.
// ----------------------------------------------------------------------------
`default_nettype none

module gmfv_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire gmfv_pkg::q_entry_t q_entry_i,
  output logic                    q_pop_o,
  gmfv_out_if.source              out_o
);

  gmfv_pkg::phase_e phase_q, phase_d;
  gmfv_pkg::err_e   err_q, err_d;
  logic [23:0] hist_q, hist_d;
  logic [2:0]  hdig_q, hdig_d;
  logic [5:0]  hbc_q, hbc_d;
  logic [31:0] cnt_q, cnt_d;
  logic [23:0] sym_q, sym_d;
  logic [31:0] first_q, first_d;
  logic [31:0] cur_q, cur_d;
  logic [31:0] rows_q, rows_d;

  // Output register.
  logic        res_valid_q;
  logic        res_ok_q;
  logic [3:0]  res_err_q;
  logic [31:0] res_cnt_q, res_len_q;
  logic [23:0] res_sym_q;

  logic stall, emit;

  // Only a closing item needs the output register; other items keep flowing.
  assign stall   = res_valid_q && !out_o.ready && q_entry_i.eof;
  assign q_pop_o = q_valid_i && !stall;
  assign emit    = q_pop_o && q_entry_i.eof;

  assign out_o.valid           = res_valid_q;
  assign out_o.valid_res       = res_ok_q;
  assign out_o.error_code      = res_err_q;
  assign out_o.row_count       = res_cnt_q;
  assign out_o.row_length      = res_len_q;
  assign out_o.empty_symbol    = res_sym_q[7:0];
  assign out_o.obstacle_symbol = res_sym_q[15:8];
  assign out_o.fill_symbol     = res_sym_q[23:16];

  // Row close, evaluated on the current state.
  gmfv_pkg::err_e close_err;
  logic [31:0]    close_first, close_rows;
  logic [31:0]    cnt_x10;
  logic [7:0]     e_sym, o_sym, f_sym;
  logic [3:0]     lead;

  always_comb begin
    close_err   = gmfv_pkg::ERR_NONE;
    close_first = first_q;
    close_rows  = rows_q;
    if (cur_q == '0) begin
      close_err = gmfv_pkg::ERR_EMPTY_ROW;
    end else if (rows_q != '0 && cur_q != first_q) begin
      close_err = gmfv_pkg::ERR_RAGGED;
    end else begin
      if (rows_q == '0) close_first = cur_q;
      if (rows_q != gmfv_pkg::ALL_ONES) close_rows = rows_q + 32'd1;
    end
  end

  always_comb begin
    e_sym   = hist_q[23:16];
    o_sym   = hist_q[15:8];
    f_sym   = hist_q[7:0];
    // Digits '0'..'9' carry their value in the low nibble.
    lead    = hist_q[19:16];
    cnt_x10 = {cnt_q[28:0], 3'b000} + {cnt_q[30:0], 1'b0} + {28'd0, lead};

    phase_d = phase_q;
    err_d   = err_q;
    hist_d  = hist_q;
    hdig_d  = hdig_q;
    hbc_d   = hbc_q;
    cnt_d   = cnt_q;
    sym_d   = sym_q;
    first_d = first_q;
    cur_d   = cur_q;
    rows_d  = rows_q;

    if (q_pop_o) begin
      if (q_entry_i.eof) begin
        // Final checks land in the output register; state restarts.
        phase_d = gmfv_pkg::PH_HEADER;
        err_d   = gmfv_pkg::ERR_NONE;
        hist_d  = '0;
        hdig_d  = '0;
        hbc_d   = '0;
        cnt_d   = '0;
        sym_d   = '0;
        first_d = '0;
        cur_d   = '0;
        rows_d  = '0;
      end else if (err_q == gmfv_pkg::ERR_NONE) begin
        if (phase_q == gmfv_pkg::PH_HEADER) begin
          if (q_entry_i.is_nl) begin
            if (hbc_q < gmfv_pkg::HBC_WINDOW) begin
              err_d = gmfv_pkg::ERR_TRUNCATED;
            end else if (cnt_q == '0 || e_sym == o_sym || e_sym == f_sym ||
                         o_sym == f_sym) begin
              err_d = gmfv_pkg::ERR_HDR_VALUE;
            end else begin
              sym_d   = {f_sym, o_sym, e_sym};
              phase_d = gmfv_pkg::PH_MAP;
            end
          end else if (!q_entry_i.is_print) begin
            err_d = gmfv_pkg::ERR_HDR_CHAR;
          end else if (hbc_q >= gmfv_pkg::HBC_WINDOW &&
                       (!hdig_q[2] || cnt_q >= gmfv_pkg::COUNT_CAP)) begin
            err_d = gmfv_pkg::ERR_DIGIT;
          end else begin
            if (hbc_q >= gmfv_pkg::HBC_WINDOW) cnt_d = cnt_x10;
            hist_d = {hist_q[15:0], q_entry_i.data};
            hdig_d = {hdig_q[1:0], q_entry_i.is_digit};
            if (hbc_q != gmfv_pkg::HBC_MAX) hbc_d = hbc_q + 6'd1;
          end
        end else begin
          if (q_entry_i.is_nl) begin
            if (close_err != gmfv_pkg::ERR_NONE) begin
              err_d = close_err;
            end else begin
              first_d = close_first;
              rows_d  = close_rows;
              cur_d   = '0;
            end
          end else if (q_entry_i.data != sym_q[7:0] && q_entry_i.data != sym_q[15:8]) begin
            err_d = gmfv_pkg::ERR_MAP_CHAR;
          end else if (rows_q != '0 && cur_q == first_q) begin
            err_d = gmfv_pkg::ERR_RAGGED;
          end else if (cur_q != gmfv_pkg::ALL_ONES) begin
            cur_d = cur_q + 32'd1;
          end
        end
      end
    end
  end

  // Verdict for an end-of-file item.
  gmfv_pkg::err_e fin_err;
  logic [31:0]    fin_first, fin_rows;

  always_comb begin
    fin_err   = err_q;
    fin_first = first_q;
    fin_rows  = rows_q;
    if (err_q == gmfv_pkg::ERR_NONE) begin
      if (phase_q == gmfv_pkg::PH_HEADER) begin
        fin_err = gmfv_pkg::ERR_TRUNCATED;
      end else begin
        if (cur_q != '0 || rows_q == '0) begin
          fin_err   = close_err;
          if (close_err == gmfv_pkg::ERR_NONE) begin
            fin_first = close_first;
            fin_rows  = close_rows;
          end
        end
        if (fin_err == gmfv_pkg::ERR_NONE && fin_rows != cnt_q) begin
          fin_err = gmfv_pkg::ERR_ROW_TOTAL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= gmfv_pkg::PH_HEADER;
      err_q       <= gmfv_pkg::ERR_NONE;
      hist_q      <= '0;
      hdig_q      <= '0;
      hbc_q       <= '0;
      cnt_q       <= '0;
      sym_q       <= '0;
      first_q     <= '0;
      cur_q       <= '0;
      rows_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      err_q   <= err_d;
      hist_q  <= hist_d;
      hdig_q  <= hdig_d;
      hbc_q   <= hbc_d;
      cnt_q   <= cnt_d;
      sym_q   <= sym_d;
      first_q <= first_d;
      cur_q   <= cur_d;
      rows_q  <= rows_d;
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_ok_q  <= (fin_err == gmfv_pkg::ERR_NONE);
      res_err_q <= fin_err;
      res_cnt_q <= cnt_q;
      res_len_q <= fin_first;
      res_sym_q <= sym_q;
    end
  end

endmodule

`default_nettype wire

[rtl/grid_map_format_validator_top.sv]
// ----------------------------------------------------------------------------
// grid_map_format_validator_top
// Streaming checker for text grid map files, one byte per item.
// ----------------------------------------------------------------------------
// Feed the file one byte per item on in_i; set end_of_file on a closing item
// (its byte is ignored) to get one verdict on out_o with the error code, the
// header row count, the first row length and the three header symbols; the
// parse state then restarts for the next file. The block takes one item per
// cycle while the queue has room: a front stage classifies each byte
// (newline, printable, digit) and pushes it into a four-entry queue, and the
// back end applies one item per cycle to the parse state unless stalled, its
// longest path being the multiply-by-ten and add of the header count. The
// verdict sits in an output register in the cycle after the closing item
// leaves the queue; while it waits to be taken, only a further closing item
// stalls the back end, and the queue absorbs up to four bytes before
// in_i.ready drops. Errors are sticky: after the first one, bytes are
// dropped until end of file, and the fields report the state at that error.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_map_format_validator_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gmfv_in_if.sink     in_i,
  gmfv_out_if.source  out_o
);

  gmfv_pkg::q_entry_t push_entry, pop_entry;
  logic               push, pop, not_full, not_empty;

  // Classify and accept bytes.
  gmfv_front u_front (
    .in_i      (in_i),
    .q_ready_i (not_full),
    .q_entry_o (push_entry),
    .q_push_o  (push)
  );

  // Decouple the front from back-end stalls.
  gmfv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .not_full_o  (not_full),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .not_empty_o (not_empty)
  );

  // Parse state and verdict register.
  gmfv_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (not_empty),
    .q_entry_i (pop_entry),
    .q_pop_o   (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire
